// ===== rtl/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared widths, codes and control structs of the bouncing LED scanner.
// ----------------------------------------------------------------------------
package lbs_pkg;

  localparam int POS_FW     = 34;  // fixed-point position width
  localparam int STEP_W     = 29;  // signed step width
  localparam int COLOR_W    = 24;
  localparam int CH_W       = 8;
  localparam int RUN_W      = 5;   // run lengths 0..16
  localparam int IDX_W      = 9;   // led_index width
  localparam int BOUND_W    = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 29;
  localparam int ALU_W      = 35;  // shared adder width

  localparam logic [STEP_W-1:0] STEP_MAX = {1'b0, {(STEP_W-1){1'b1}}};
  localparam logic [STEP_W-1:0] STEP_MIN = {1'b1, {(STEP_W-1){1'b0}}};
  localparam logic [POS_FW-1:0] POS_MAX  = {1'b0, {(POS_FW-1){1'b1}}};
  localparam logic [POS_FW-1:0] POS_MIN  = {1'b1, {(POS_FW-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BAR_COLOR = 3'd0,
    REG_STEP_SIZE = 3'd1,
    REG_BAR_LEN   = 3'd2,
    REG_BLANK_CNT = 3'd3,
    REG_LOWER     = 3'd4,
    REG_UPPER     = 3'd5,
    REG_START_POS = 3'd6
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS,
    ST_END,
    ST_DLO,
    ST_DHI,
    ST_LO,
    ST_HI,
    ST_BAR,
    ST_BOUNCE,
    ST_ADV
  } lbs_state_e;

  typedef enum logic [2:0] {
    SEL_END,
    SEL_DLO,
    SEL_DHI,
    SEL_IDX_LO,
    SEL_IDX_HI,
    SEL_IDX_BAR,
    SEL_NEG,
    SEL_ADV
  } alu_sel_e;

  typedef struct packed {
    logic             start;
    logic             out_free;
    logic [RUN_W-1:0] n_lo;
    logic [RUN_W-1:0] n_hi;
    logic [RUN_W-1:0] len;
  } lbs_status_t;

  typedef struct packed {
    logic             in_ready;
    alu_sel_e         sel;
    logic             ld_pos;
    logic             ld_end;
    logic             ld_dlo;
    logic             ld_dhi;
    logic             ld_step;
    logic             ld_pf;
    logic             emit;
    logic             last;
    logic [RUN_W-1:0] k;
  } lbs_ctrl_t;

endpackage

// ===== rtl/lbs_in_if.sv =====
// ----------------------------------------------------------------------------
// lbs_in_if
// Frame tick request channel.
// ----------------------------------------------------------------------------
interface lbs_in_if ();
  logic valid;
  logic ready;
  logic frame_tick;

  modport source (output valid, output frame_tick, input ready);
  modport sink   (input valid, input frame_tick, output ready);
endinterface

// ===== rtl/lbs_out_if.sv =====
// ----------------------------------------------------------------------------
// lbs_out_if
// LED write request channel.
// ----------------------------------------------------------------------------
interface lbs_out_if import lbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] led_index;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;
  logic             last_write;

  modport source (output valid, output led_index, output red, output green,
                  output blue, output last_write, input ready);
  modport sink   (input valid, input led_index, input red, input green,
                  input blue, input last_write, output ready);
endinterface

// ===== rtl/lbs_alu.sv =====
// ----------------------------------------------------------------------------
// lbs_alu
// Shared adder: a + (b or ~b) + carry, with sign and zero flags.
// ----------------------------------------------------------------------------
module lbs_alu import lbs_pkg::*; (
  input  logic signed [ALU_W-1:0] a_i,
  input  logic signed [ALU_W-1:0] b_i,
  input  logic                    inv_i,
  input  logic                    cin_i,
  output logic signed [ALU_W-1:0] sum_o,
  output logic                    neg_o,
  output logic                    zero_o
);

  logic [ALU_W-1:0] b_op;

  assign b_op   = inv_i ? ~b_i : b_i;
  assign sum_o  = $signed(a_i + b_op + {{(ALU_W-1){1'b0}}, cin_i});
  assign neg_o  = sum_o[ALU_W-1];
  assign zero_o = (sum_o == '0);

endmodule

// ===== rtl/lbs_seq.sv =====
// ----------------------------------------------------------------------------
// lbs_seq
// Frame sequencer: setup steps, three write runs, bounce and advance.
// ----------------------------------------------------------------------------
module lbs_seq import lbs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lbs_status_t status_i,
  output lbs_ctrl_t   ctrl_o
);

  lbs_state_e       state_q, state_d;
  logic [RUN_W-1:0] k_q, k_d;
  logic             lo_end, hi_end, bar_end;

  // final write of each run
  assign lo_end  = (k_q == status_i.n_lo - RUN_W'(1));
  assign hi_end  = (k_q == status_i.n_hi - RUN_W'(1));
  assign bar_end = (k_q == status_i.len - RUN_W'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // next state and run counter
  always_comb begin
    state_d = state_q;
    k_d     = '0;
    case (state_q)
      ST_IDLE: begin
        if (status_i.start) state_d = ST_POS;
      end
      ST_POS: state_d = ST_END;
      ST_END: state_d = ST_DLO;
      ST_DLO: state_d = ST_DHI;
      ST_DHI: state_d = ST_LO;
      ST_LO: begin
        if (status_i.n_lo == '0) begin
          state_d = ST_HI;
        end else if (!status_i.out_free) begin
          k_d = k_q;
        end else if (lo_end) begin
          state_d = ST_HI;
        end else begin
          k_d = k_q + RUN_W'(1);
        end
      end
      ST_HI: begin
        if (status_i.n_hi == '0) begin
          state_d = ST_BAR;
        end else if (!status_i.out_free) begin
          k_d = k_q;
        end else if (hi_end) begin
          state_d = ST_BAR;
        end else begin
          k_d = k_q + RUN_W'(1);
        end
      end
      ST_BAR: begin
        if (status_i.len == '0) begin
          state_d = ST_BOUNCE;
        end else if (!status_i.out_free) begin
          k_d = k_q;
        end else if (bar_end) begin
          state_d = ST_BOUNCE;
        end else begin
          k_d = k_q + RUN_W'(1);
        end
      end
      ST_BOUNCE: state_d = ST_ADV;
      ST_ADV:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctrl_o          = '0;
    ctrl_o.sel      = SEL_END;
    ctrl_o.k        = k_q;
    case (state_q)
      ST_IDLE: ctrl_o.in_ready = 1'b1;
      ST_POS:  ctrl_o.ld_pos   = 1'b1;
      ST_END: begin
        ctrl_o.sel    = SEL_END;
        ctrl_o.ld_end = 1'b1;
      end
      ST_DLO: begin
        ctrl_o.sel    = SEL_DLO;
        ctrl_o.ld_dlo = 1'b1;
      end
      ST_DHI: begin
        ctrl_o.sel    = SEL_DHI;
        ctrl_o.ld_dhi = 1'b1;
      end
      ST_LO: begin
        ctrl_o.sel  = SEL_IDX_LO;
        ctrl_o.emit = (status_i.n_lo != '0) && status_i.out_free;
        ctrl_o.last = ctrl_o.emit && lo_end && (status_i.n_hi == '0) &&
                      (status_i.len == '0);
      end
      ST_HI: begin
        ctrl_o.sel  = SEL_IDX_HI;
        ctrl_o.emit = (status_i.n_hi != '0) && status_i.out_free;
        ctrl_o.last = ctrl_o.emit && hi_end && (status_i.len == '0);
      end
      ST_BAR: begin
        ctrl_o.sel  = SEL_IDX_BAR;
        ctrl_o.emit = (status_i.len != '0) && status_i.out_free;
        ctrl_o.last = ctrl_o.emit && bar_end;
      end
      ST_BOUNCE: begin
        ctrl_o.sel     = SEL_NEG;
        ctrl_o.ld_step = 1'b1;
      end
      ST_ADV: begin
        ctrl_o.sel   = SEL_ADV;
        ctrl_o.ld_pf = 1'b1;
      end
      default: ctrl_o.in_ready = 1'b0;
    endcase
  end

endmodule

// ===== rtl/bouncing_led_scanner_unit.sv =====
// ----------------------------------------------------------------------------
// bouncing_led_scanner_unit
// Larson-style bouncing bar: LED write requests per frame tick.
// ----------------------------------------------------------------------------
// A frame tick request with frame_tick = 1 produces the LED write requests of
// one frame: black blanking writes below the bar (down to lower_bound), black
// blanking writes just past the bar (up to upper_bound), then bar_length
// writes in bar_color; last_write marks the final write. The position then
// bounces and advances by the signed fixed-point step. One shared adder does
// the arithmetic of each step, one operation per cycle while a write run is
// not held by a stalled output. A frame runs request acceptance, the setup
// steps, the three runs of writes, then the bounce and the advance. A request
// with frame_tick = 0 gives no write. No new request is taken while a frame
// is in progress. Configuration writes land at once; step_size also reloads
// the live step and start_position reloads the position.
module bouncing_led_scanner_unit import lbs_pkg::*; #(
  parameter int LED_COUNT = 256,
  parameter int FRAC_BITS = 24,
  parameter int MAX_RUN   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  lbs_in_if.sink                req_i,
  lbs_out_if.source             wr_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int PW = $clog2(LED_COUNT + 1);
  localparam int EW = $clog2(LED_COUNT + MAX_RUN + 1);

  // configuration registers
  logic [COLOR_W-1:0] color_q;
  logic [RUN_W-1:0]   len_cfg_q;
  logic [RUN_W-1:0]   blank_cfg_q;
  logic [BOUND_W-1:0] lower_q;
  logic [BOUND_W-1:0] upper_q;

  // animation state
  logic signed [POS_FW-1:0] pf_q;
  logic signed [STEP_W-1:0] step_q;

  // per-frame working registers
  logic [PW-1:0]    pos_q;
  logic [EW-1:0]    end_q;
  logic [RUN_W-1:0] n_lo_q, n_hi_q;
  logic             lo_hit_q, hi_hit_q;

  // output register
  logic             out_valid_q;
  logic [IDX_W-1:0] out_idx_q;
  logic [COLOR_W-1:0] out_color_q;
  logic             out_last_q;

  lbs_status_t status;
  lbs_ctrl_t   ctrl;

  logic signed [ALU_W-1:0] alu_a, alu_b, alu_sum;
  logic                    alu_inv, alu_cin, alu_neg, alu_zero;

  logic [RUN_W-1:0]        len_c, blanks_c;
  logic [POS_FW-1:0]       ipart;
  logic [PW-1:0]           pos_c;
  logic signed [ALU_W-1:0] pos_x, end_x, lower_x, upper_x, k_x, len_x, blanks_x;
  logic signed [ALU_W-1:0] step_x, pf_x;
  logic                    step_pos, step_neg;
  logic [STEP_W-1:0]       neg_sat, step_c;
  logic [POS_FW-1:0]       pf_c;
  logic                    out_free;

  // clamp run lengths to MAX_RUN
  assign len_c    = (len_cfg_q > RUN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : len_cfg_q;
  assign blanks_c = (blank_cfg_q > RUN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : blank_cfg_q;

  // integer position: floor, saturated to 0..LED_COUNT
  assign ipart = $unsigned(pf_q) >> FRAC_BITS;
  always_comb begin
    if (pf_q[POS_FW-1]) begin
      pos_c = '0;
    end else if (ipart > POS_FW'(LED_COUNT)) begin
      pos_c = PW'(LED_COUNT);
    end else begin
      pos_c = ipart[PW-1:0];
    end
  end

  // operand extension to the adder width
  assign pos_x    = $signed({{(ALU_W-PW){1'b0}}, pos_q});
  assign end_x    = $signed({{(ALU_W-EW){1'b0}}, end_q});
  assign lower_x  = $signed({{(ALU_W-BOUND_W){1'b0}}, lower_q});
  assign upper_x  = $signed({{(ALU_W-BOUND_W){1'b0}}, upper_q});
  assign k_x      = $signed({{(ALU_W-RUN_W){1'b0}}, ctrl.k});
  assign len_x    = $signed({{(ALU_W-RUN_W){1'b0}}, len_c});
  assign blanks_x = $signed({{(ALU_W-RUN_W){1'b0}}, blanks_c});
  assign step_x   = $signed({{(ALU_W-STEP_W){step_q[STEP_W-1]}}, step_q});
  assign pf_x     = $signed({{(ALU_W-POS_FW){pf_q[POS_FW-1]}}, pf_q});

  // operand select for the shared adder; pos + ~k gives pos - 1 - k
  always_comb begin
    alu_a   = pos_x;
    alu_b   = len_x;
    alu_inv = 1'b0;
    alu_cin = 1'b0;
    case (ctrl.sel)
      SEL_END: begin
        alu_a = pos_x;
        alu_b = len_x;
      end
      SEL_DLO: begin
        alu_a   = pos_x;
        alu_b   = lower_x;
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      SEL_DHI: begin
        alu_a   = upper_x;
        alu_b   = end_x;
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      SEL_IDX_LO: begin
        alu_a   = pos_x;
        alu_b   = k_x;
        alu_inv = 1'b1;
      end
      SEL_IDX_HI: begin
        alu_a = end_x;
        alu_b = k_x;
      end
      SEL_IDX_BAR: begin
        alu_a = pos_x;
        alu_b = k_x;
      end
      SEL_NEG: begin
        alu_a   = '0;
        alu_b   = step_x;
        alu_inv = 1'b1;
        alu_cin = 1'b1;
      end
      SEL_ADV: begin
        alu_a = pf_x;
        alu_b = step_x;
      end
      default: alu_a = pos_x;
    endcase
  end

  lbs_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .inv_i (alu_inv),
    .cin_i (alu_cin),
    .sum_o (alu_sum),
    .neg_o (alu_neg),
    .zero_o(alu_zero)
  );

  // bounce: at most one net negation; the most negative step saturates
  assign step_pos = !step_q[STEP_W-1] && (step_q != '0);
  assign step_neg = step_q[STEP_W-1];
  assign neg_sat  = (step_q == STEP_MIN) ? STEP_MAX : alu_sum[STEP_W-1:0];
  always_comb begin
    if (hi_hit_q && step_pos) begin
      step_c = lo_hit_q ? step_q : alu_sum[STEP_W-1:0];
    end else if (lo_hit_q && step_neg) begin
      step_c = neg_sat;
    end else begin
      step_c = step_q;
    end
  end

  // advance: saturate to the signed position range
  always_comb begin
    if (alu_sum[ALU_W-1] != alu_sum[POS_FW-1]) begin
      pf_c = alu_sum[ALU_W-1] ? POS_MIN : POS_MAX;
    end else begin
      pf_c = alu_sum[POS_FW-1:0];
    end
  end

  assign out_free = !out_valid_q || wr_o.ready;

  assign status.start    = req_i.valid && req_i.ready && req_i.frame_tick;
  assign status.out_free = out_free;
  assign status.n_lo     = n_lo_q;
  assign status.n_hi     = n_hi_q;
  assign status.len      = len_c;

  lbs_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .status_i(status),
    .ctrl_o  (ctrl)
  );

  assign req_i.ready = ctrl.in_ready;

  // configuration and animation state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q     <= COLOR_W'(24'hFF0000);
      len_cfg_q   <= RUN_W'(8);
      blank_cfg_q <= RUN_W'(4);
      lower_q     <= '0;
      upper_q     <= BOUND_W'(256);
      step_q      <= STEP_W'(33554432);
      pf_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_BAR_COLOR: color_q     <= cfg_data_i[COLOR_W-1:0];
          REG_STEP_SIZE: step_q      <= cfg_data_i[STEP_W-1:0];
          REG_BAR_LEN:   len_cfg_q   <= cfg_data_i[RUN_W-1:0];
          REG_BLANK_CNT: blank_cfg_q <= cfg_data_i[RUN_W-1:0];
          REG_LOWER:     lower_q     <= cfg_data_i[BOUND_W-1:0];
          REG_UPPER:     upper_q     <= cfg_data_i[BOUND_W-1:0];
          REG_START_POS: pf_q        <= $signed(POS_FW'(cfg_data_i[BOUND_W-1:0]) << FRAC_BITS);
          default:       color_q     <= color_q;
        endcase
      end else begin
        if (ctrl.ld_step) step_q <= step_c;
        if (ctrl.ld_pf)   pf_q   <= pf_c;
      end
    end
  end

  // per-frame working values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      end_q    <= '0;
      n_lo_q   <= '0;
      n_hi_q   <= '0;
      lo_hit_q <= 1'b0;
      hi_hit_q <= 1'b0;
    end else begin
      if (ctrl.ld_pos) pos_q <= pos_c;
      if (ctrl.ld_end) end_q <= alu_sum[EW-1:0];
      // blanks below: pos - i >= lower for i = 1 .. min(pos - lower, blanks)
      if (ctrl.ld_dlo) begin
        if (alu_neg)                 n_lo_q <= '0;
        else if (alu_sum >= blanks_x) n_lo_q <= blanks_c;
        else                         n_lo_q <= alu_sum[RUN_W-1:0];
        lo_hit_q <= alu_neg || (alu_sum <= len_x);
      end
      // blanks past: end + i <= upper for i = 0 .. min(upper - end, blanks - 1)
      if (ctrl.ld_dhi) begin
        if (alu_neg)                 n_hi_q <= '0;
        else if (alu_sum >= blanks_x) n_hi_q <= blanks_c;
        else                         n_hi_q <= alu_sum[RUN_W-1:0] + RUN_W'(1);
        hi_hit_q <= alu_neg || alu_zero;
      end
    end
  end

  // output register: load on emit, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (wr_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      out_idx_q   <= alu_sum[IDX_W-1:0];
      out_color_q <= (ctrl.sel == SEL_IDX_BAR) ? color_q : '0;
      out_last_q  <= ctrl.last;
    end
  end

  assign wr_o.valid      = out_valid_q;
  assign wr_o.led_index  = out_idx_q;
  assign wr_o.red        = out_color_q[23:16];
  assign wr_o.green      = out_color_q[15:8];
  assign wr_o.blue       = out_color_q[7:0];
  assign wr_o.last_write = out_last_q;

  // a started frame holds off further requests
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.start |=> !req_i.ready)
    else $error("request accepted during a frame");

  // a write is only produced into a free output slot
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |-> out_free)
    else $error("write produced over a pending write");

  // lower blanking writes never go below lower_bound
  a_lo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.emit && ctrl.sel == SEL_IDX_LO) |-> (alu_sum >= lower_x))
    else $error("blanking write below lower bound");

  // bar run counter stays inside the bar
  a_bar_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.emit && ctrl.sel == SEL_IDX_BAR) |-> (ctrl.k < len_c))
    else $error("bar write past bar length");

endmodule

// ===== test/bouncing_led_scanner_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bouncing_led_scanner_unit_tb
// Self-checking bench for the bouncing bar scanner. Frame tick requests go
// in on one channel and LED write requests come out on the other. A
// scoreboard class tracks the bar position, the live step and the register
// file. It predicts every write of a frame and compares the writes in order.
// A short directed part covers the corner cases. Random phases then rotate the
// setups and the idle patterns. They include a long output hold-off and a full
// drain in mid-stream.
// ----------------------------------------------------------------------------
module bouncing_led_scanner_unit_tb;
  import lbs_pkg::*;

  localparam int LED_COUNT = 256;
  localparam int FRAC_BITS = 24;
  localparam int MAX_RUN   = 16;

  // Saturation limits of the live step and the fixed-point position.
  localparam longint STEP_TOP   = (longint'(1) << (STEP_W - 1)) - 1;
  localparam longint STEP_FLOOR = -(longint'(1) << (STEP_W - 1));
  localparam longint POS_TOP    = (longint'(1) << (POS_FW - 1)) - 1;
  localparam longint POS_FLOOR  = -(longint'(1) << (POS_FW - 1));

  // Index 7 decodes to no register.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  // Long enough for the worst frame with no output traffic, so this covers the tail.
  localparam int FRAME_TAIL  = 64;
  localparam int DRAIN_LIMIT = 50000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_TICKS = 51;

  typedef struct packed {
    logic [IDX_W-1:0] led_index;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             last_write;
  } led_write_t;

  // --------------------------------------------------------------------------
  // Scoreboard: a mirror of the register file and the bar motion, plus the
  // queue of LED writes that the accepted frames still owe.
  // --------------------------------------------------------------------------
  class led_write_scoreboard;
    logic [COLOR_W-1:0] color_reg;
    logic [RUN_W-1:0]   length_reg;
    logic [RUN_W-1:0]   blanks_reg;
    logic [BOUND_W-1:0] low_reg;
    logic [BOUND_W-1:0] high_reg;
    longint             pos_fx;
    longint             live_step;
    led_write_t         owed_writes[$];
    int                 errors;

    function new();
      color_reg  = 24'hFF0000;
      length_reg = 5'd8;
      blanks_reg = 5'd4;
      low_reg    = '0;
      high_reg   = 9'd256;
      pos_fx     = 0;
      live_step  = 33554432;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BAR_COLOR: color_reg = data[COLOR_W-1:0];
        REG_STEP_SIZE: live_step = $signed(data);
        REG_BAR_LEN:   length_reg = data[RUN_W-1:0];
        REG_BLANK_CNT: blanks_reg = data[RUN_W-1:0];
        REG_LOWER:     low_reg = data[BOUND_W-1:0];
        REG_UPPER:     high_reg = data[BOUND_W-1:0];
        REG_START_POS: pos_fx = longint'(data[BOUND_W-1:0]) << FRAC_BITS;
        default: ;
      endcase
    endfunction

    function void push_write(longint idx, logic [COLOR_W-1:0] color);
      led_write_t w;
      w.led_index  = idx[IDX_W-1:0];
      w.red        = color[23:16];
      w.green      = color[15:8];
      w.blue       = color[7:0];
      w.last_write = 1'b0;
      owed_writes.push_back(w);
    endfunction

    // One accepted request: queue the frame's writes, then bounce and advance.
    function void note_request(logic tick);
      longint origin, len, blanks, lo, hi, i;
      int     first;
      if (!tick) return;
      if (pos_fx < 0) origin = 0;
      else origin = pos_fx >>> FRAC_BITS;
      if (origin > LED_COUNT) origin = LED_COUNT;
      len    = length_reg;
      blanks = blanks_reg;
      lo     = low_reg;
      hi     = high_reg;
      if (len > MAX_RUN) len = MAX_RUN;
      if (blanks > MAX_RUN) blanks = MAX_RUN;
      first = owed_writes.size();
      for (i = 1; i <= blanks; i++)
        if (origin - i >= lo) push_write(origin - i, '0);
      for (i = 0; i < blanks; i++)
        if (origin + len + i <= hi) push_write(origin + len + i, '0);
      for (i = 0; i < len; i++)
        push_write(origin + i, color_reg);
      if (owed_writes.size() > first)
        owed_writes[owed_writes.size() - 1].last_write = 1'b1;

      if (origin + len >= hi && live_step > 0) live_step = -live_step;
      if (origin <= lo + len && live_step < 0)
        live_step = (live_step == STEP_FLOOR) ? STEP_TOP : -live_step;
      pos_fx = pos_fx + live_step;
      if (pos_fx > POS_TOP) pos_fx = POS_TOP;
      if (pos_fx < POS_FLOOR) pos_fx = POS_FLOOR;
    endfunction

    function void check_write(led_write_t got);
      led_write_t want;
      if (owed_writes.size() == 0) begin
        $display("%0t: unexpected LED write idx %0d rgb %06h last %0b", $time,
                 got.led_index, {got.red, got.green, got.blue}, got.last_write);
        errors++;
        return;
      end
      want = owed_writes.pop_front();
      if (got.led_index !== want.led_index || got.red !== want.red ||
          got.green !== want.green || got.blue !== want.blue ||
          got.last_write !== want.last_write) begin
        $display({"%0t: LED write mismatch: expected idx %0d rgb %06h last %0b, ",
                  "got idx %0d rgb %06h last %0b"},
                 $time, want.led_index, {want.red, want.green, want.blue},
                 want.last_write,
                 got.led_index, {got.red, got.green, got.blue}, got.last_write);
        errors++;
      end
    endfunction

    function int pending();
      return owed_writes.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lbs_in_if  req_if ();
  lbs_out_if wr_if ();

  led_write_scoreboard sb;

  // Idle percentages of the current phase and the hold-off handed to the sink.
  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_request;

  bouncing_led_scanner_unit #(
    .LED_COUNT(LED_COUNT),
    .FRAC_BITS(FRAC_BITS),
    .MAX_RUN  (MAX_RUN)
  ) dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_i     (req_if),
    .wr_o      (wr_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #50_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sink side: stall at random, or hold ready low for a counted stretch when
  // the stimulus asks for one.
  // --------------------------------------------------------------------------
  initial begin : write_sink
    int hold_left;
    hold_left = 0;
    wr_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        wr_if.ready <= 1'b0;
        hold_left--;
      end else begin
        wr_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Check every accepted LED write request against the oldest prediction.
  initial begin : write_monitor
    led_write_t got;
    forever begin
      @(posedge clk);
      if (rst_n && wr_if.valid && wr_if.ready) begin
        got.led_index  = wr_if.led_index;
        got.red        = wr_if.red;
        got.green      = wr_if.green;
        got.blue       = wr_if.blue;
        got.last_write = wr_if.last_write;
        sb.check_write(got);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Offer one frame request, idling first at the phase's rate. Leave valid
  // high on return so a back-to-back request keeps it up without a glitch.
  task automatic send_request(logic tick);
    while ($urandom_range(99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.frame_tick <= tick;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(tick);
  endtask

  // Write one register. Leave the enable up; the caller drops it after a batch.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Drop valid, wait for every owed write, then let a silent frame finish.
  task automatic settle();
    int waited;
    req_if.valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() != 0) begin
      $display("%0t: %0d LED writes never arrived", $time, sb.pending());
      sb.errors++;
      sb.owed_writes.delete();
    end
    repeat (FRAME_TAIL) @(posedge clk);
  endtask

  // Program a full setup while the block is idle.
  task automatic setup(logic [COLOR_W-1:0] color, logic [STEP_W-1:0] step,
                       logic [RUN_W-1:0] len, logic [RUN_W-1:0] blanks,
                       logic [BOUND_W-1:0] lo, logic [BOUND_W-1:0] hi,
                       logic [BOUND_W-1:0] start);
    settle();
    write_reg(REG_BAR_COLOR, CFG_DATA_W'(color));
    write_reg(REG_STEP_SIZE, CFG_DATA_W'(step));
    write_reg(REG_BAR_LEN, CFG_DATA_W'(len));
    write_reg(REG_BLANK_CNT, CFG_DATA_W'(blanks));
    write_reg(REG_LOWER, CFG_DATA_W'(lo));
    write_reg(REG_UPPER, CFG_DATA_W'(hi));
    write_reg(REG_START_POS, CFG_DATA_W'(start));
    cfg_we <= 1'b0;
  endtask

  // Random setup. A sane one keeps the bar bouncing inside ordered bounds
  // with a modest step; a wild one takes any value the registers hold.
  task automatic random_setup(bit wild);
    int               len, blanks, lo, hi, start, mag;
    logic [STEP_W-1:0] step;
    if (wild) begin
      step   = STEP_W'($urandom);
      len    = $urandom_range(0, 31);
      blanks = $urandom_range(0, 31);
      lo     = $urandom_range(0, 511);
      hi     = $urandom_range(0, 511);
      start  = $urandom_range(0, 511);
    end else begin
      len    = $urandom_range(1, MAX_RUN);
      blanks = $urandom_range(0, MAX_RUN);
      lo     = $urandom_range(0, 100);
      hi     = $urandom_range(lo + len + 4, LED_COUNT);
      start  = $urandom_range(lo, hi);
      mag    = $urandom_range(1 << 19, 1 << 26);
      step   = $urandom_range(1) ? STEP_W'(mag) : STEP_W'(-mag);
    end
    setup(COLOR_W'($urandom), step, RUN_W'(len), RUN_W'(blanks),
          BOUND_W'(lo), BOUND_W'(hi), BOUND_W'(start));
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int   ticks;
    logic tick;

    // Known values on every input before the first edge.
    req_if.valid       = 1'b0;
    req_if.frame_tick  = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = '0;
    cfg_data           = '0;
    rst_n              = 1'b0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_request       = 0;
    sb = new();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setup, with an empty tick in between.
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b1);

    // Full white, longest runs, one LED per frame.
    setup(24'hFFFFFF, 29'h100_0000, 5'd16, 5'd16, 9'd0, 9'd256, 9'd100);
    send_request(1'b1);
    send_request(1'b1);

    // Zero length and no blanks: frames with no writes still move the bar.
    setup(24'h000000, 29'h080_0000, 5'd0, 5'd0, 9'd0, 9'd256, 9'd40);
    send_request(1'b1);
    send_request(1'b1);

    // Oversized length and blanks clamp to the maximum run.
    setup(24'hA5C35A, 29'h180_0000, 5'd31, 5'd31, 9'd10, 9'd250, 9'd120);
    send_request(1'b1);
    send_request(1'b1);

    // Bar past the end: a start at LED_COUNT puts the bar beyond the last LED.
    setup(24'h123456, 29'h080_0000, 5'd16, 5'd5, 9'd200, 9'd511, 9'd256);
    send_request(1'b1);
    send_request(1'b1);

    // Most negative step near the low bound: negation saturates.
    setup(24'h00FF00, 29'h1000_0000, 5'd8, 5'd2, 9'd0, 9'd256, 9'd5);
    send_request(1'b1);
    send_request(1'b1);

    // Largest step that never turns: the fixed-point position saturates.
    setup(24'h0000FF, 29'h0FFF_FFFF, 5'd4, 5'd3, 9'd0, 9'd511, 9'd511);
    send_request(1'b1);
    send_request(1'b1);
    send_request(1'b1);

    // Bounds tighter than the bar, then crossed bounds.
    setup(24'hFF00FF, 29'h1FF0_0000, 5'd12, 5'd4, 9'd2, 9'd3, 9'd1);
    send_request(1'b1);
    send_request(1'b1);
    setup(24'h808080, 29'h040_0000, 5'd3, 5'd6, 9'd511, 9'd0, 9'd0);
    send_request(1'b1);

    // The unused index must leave every register alone.
    settle();
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    send_request(1'b1);

    // Random phases: rotate the idle patterns, mostly sane setups.
    for (int phase = 0; phase < 8; phase++) begin
      settle();
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 68; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 68; end
        default: begin sender_idle_pct = 6; receiver_stall_pct = 6; end
      endcase
      random_setup(phase == 5 || phase == 7);
      ticks = 0;
      while (ticks < PHASE_TICKS) begin
        tick = ($urandom_range(9) != 0);
        send_request(tick);
        if (tick) begin
          ticks++;
          // Hold the output off while requests keep coming, so the block
          // backs up and stalls its input.
          if (phase == 4 && ticks == 20) hold_request = HOLD_CYCLES;
          // Pause the sender until the block has delivered everything.
          if (phase == 1 && ticks == 30) settle();
        end
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== bouncing_led_scanner_unit.f =====
rtl/lbs_pkg.sv
rtl/lbs_in_if.sv
rtl/lbs_out_if.sv
rtl/lbs_alu.sv
rtl/lbs_seq.sv
rtl/bouncing_led_scanner_unit.sv
test/bouncing_led_scanner_unit_tb.sv
